// File: rtl/nad_pkg.sv
// Shared constants, types and helpers for the AIS payload dearmor block.
// No dependencies; imported by nad_char_decode and nmea_ais_payload_dearmor.
package nad_pkg;

	// Character codes
	localparam logic [7:0] CH_LF    = 8'd10;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_A     = 8'h41;
	localparam logic [7:0] CH_I     = 8'h49;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_STAR  = 8'h2A;

	// Armoring alphabet and dearmor offsets
	localparam logic [7:0] ARMOR_LO1  = 8'd48;
	localparam logic [7:0] ARMOR_HI1  = 8'd87;
	localparam logic [7:0] ARMOR_LO2  = 8'd96;
	localparam logic [7:0] ARMOR_HI2  = 8'd119;
	localparam logic [7:0] ARMOR_BASE = 8'd48;
	localparam logic [7:0] ARMOR_KNEE = 8'd40;
	localparam logic [7:0] ARMOR_GAP  = 8'd8;

	// Line prefix length and the line position at which the prefix is decided
	localparam int unsigned PREFIX_LEN = 3;
	localparam logic [1:0]  POS_DECIDED = 2'd3;

	// Field counter default limit
	localparam int unsigned MAX_FIELDS_DEF = 8;

	// Configuration register width and reset value
	localparam int unsigned PFI_W = 3;
	localparam logic [PFI_W-1:0] PFI_RESET = 3'd5;

	// Widths of the result word
	localparam int unsigned SYM_W  = 6;
	localparam int unsigned LEN_W  = 8;
	localparam int unsigned CHAR_W = 8;
	localparam int unsigned OUT_TDATA_W = 16;

	// Per-character classification
	typedef struct packed {
		logic             eol;
		logic             delim;
		logic             bad;
		logic [SYM_W-1:0] sym;
	} char_class_t;

	// Expected prefix character at a line position
	function automatic logic [7:0] prefix_char(input logic [1:0] pos);
		logic [7:0] ch;
		case (pos)
			2'd0: ch = CH_BANG;
			2'd1: ch = CH_A;
			2'd2: ch = CH_I;
			default: ch = CH_BANG;
		endcase
		return ch;
	endfunction

endpackage

// File: rtl/nad_char_decode.sv
// Classifies one sentence character and dearmors it to a six-bit symbol.
// Depends on nad_pkg.
module nad_char_decode (
	input  logic [7:0]           char_in,
	output nad_pkg::char_class_t cls
);
	import nad_pkg::*;

	logic       in_alpha;
	logic [7:0] diff;
	logic [7:0] shifted;

	// Check the two armoring ranges
	assign in_alpha = ((char_in >= ARMOR_LO1) && (char_in <= ARMOR_HI1)) ||
	                  ((char_in >= ARMOR_LO2) && (char_in <= ARMOR_HI2));

	// Subtract the base, then close the gap above the knee
	assign diff    = char_in - ARMOR_BASE;
	assign shifted = (diff > ARMOR_KNEE) ? (diff - ARMOR_GAP) : diff;

	always_comb begin
		cls.eol   = (char_in == CH_LF) || (char_in == CH_CR);
		cls.delim = (char_in == CH_COMMA) || (char_in == CH_STAR);
		cls.bad   = !in_alpha;
		cls.sym   = in_alpha ? shifted[SYM_W-1:0] : '0;
	end

endmodule

// File: rtl/nmea_ais_payload_dearmor.sv
// Path: input register, decode logic, output register; the output register drives m_tvalid.
// Throughput: one character per cycle while m_tready does not stall a full output register.
// A character that yields no result passes through the input register and nothing more.
// Reset (arst_n low, asynchronous): line state to start of line, payload field index to 5,
// input and output registers empty.
module nmea_ais_payload_dearmor #(
	parameter int unsigned MAX_FIELDS = nad_pkg::MAX_FIELDS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration: payload_field_index
	input  logic                             cfg_we,
	input  logic [nad_pkg::PFI_W-1:0]        cfg_wdata,
	// input stream; tdata: [7:0] char_in
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [7:0]                       s_tdata,
	// output stream; tdata: [5:0] symbol, [6] bad_char, [14:7] payload_length, [15] zero
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [nad_pkg::OUT_TDATA_W-1:0]  m_tdata,
	// tuser: [0] end_of_sentence
	output logic                             m_tuser
);
	import nad_pkg::*;

	localparam int unsigned FC_W  = $clog2(MAX_FIELDS + 1);
	localparam int unsigned CMP_W = (FC_W > PFI_W) ? FC_W : PFI_W;
	localparam logic [FC_W-1:0] FC_MAX = FC_W'(MAX_FIELDS);

	// Input stage
	logic              valid_s1;
	logic [CHAR_W-1:0] char_s1;
	logic              advance;

	// Line state
	logic [1:0]        pos_q;
	logic              match_q;
	logic [FC_W-1:0]   fc_q;
	logic [LEN_W-1:0]  sc_q;
	logic [PFI_W-1:0]  pfi_q;

	// Output stage
	logic              out_valid_s2;
	logic              eos_s2;
	logic [SYM_W-1:0]  sym_s2;
	logic              bad_s2;
	logic [LEN_W-1:0]  len_s2;

	char_class_t       cls;
	logic              decided;
	logic              line_ok;
	logic              in_payload;
	logic              emit;
	logic              emit_end;
	logic [LEN_W-1:0]  sc_inc;

	nad_char_decode u_decode (
		.char_in (char_s1),
		.cls     (cls)
	);

	// Advance the input word when the output slot is free or being drained
	assign advance  = valid_s1 && (!out_valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	// Capture accepted characters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			char_s1 <= s_tdata;
		end
	end

	// Decide what the current character produces
	assign decided    = (pos_q == POS_DECIDED);
	assign line_ok    = decided && match_q;
	assign in_payload = line_ok && !cls.eol && !cls.delim && (fc_q < FC_MAX) &&
	                    (CMP_W'(fc_q) == CMP_W'(pfi_q));
	assign emit_end   = line_ok && cls.eol;
	assign emit       = emit_end || in_payload;
	assign sc_inc     = (sc_q == {LEN_W{1'b1}}) ? sc_q : (sc_q + LEN_W'(1));

	// Hold the payload field index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pfi_q <= PFI_RESET;
		end else if (cfg_we) begin
			pfi_q <= cfg_wdata;
		end
	end

	// Update line state per character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			match_q <= 1'b1;
			fc_q    <= '0;
			sc_q    <= '0;
		end else if (advance) begin
			if (cls.eol) begin
				pos_q   <= '0;
				match_q <= 1'b1;
				fc_q    <= '0;
				sc_q    <= '0;
			end else begin
				if (!decided) begin
					if (char_s1 != prefix_char(pos_q)) begin
						match_q <= 1'b0;
					end
					pos_q <= pos_q + 2'd1;
				end
				if (cls.delim && (fc_q < FC_MAX)) begin
					fc_q <= fc_q + FC_W'(1);
				end
				if (in_payload) begin
					sc_q <= sc_inc;
				end
			end
		end
	end

	// Load or drain the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (advance) begin
			out_valid_s2 <= emit;
		end else if (m_tready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			eos_s2 <= emit_end;
			sym_s2 <= emit_end ? '0 : cls.sym;
			bad_s2 <= emit_end ? 1'b0 : cls.bad;
			len_s2 <= emit_end ? sc_q : sc_inc;
		end
	end

	assign m_tvalid = out_valid_s2;
	assign m_tuser  = eos_s2;
	assign m_tdata  = {1'b0, len_s2, bad_s2, sym_s2};

`ifndef SYNTH
	// End results carry no symbol and no bad flag
	a_end_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata[6:0] == '0))
		else $error("end result with symbol bits set");

	// A bad byte always reads as symbol zero
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[6]) |-> (m_tdata[5:0] == '0))
		else $error("bad byte with nonzero symbol");

	// Field counter saturates at its limit
	a_fc_sat: assert property (@(posedge clk) disable iff (!arst_n)
		fc_q <= FC_MAX)
		else $error("field counter past limit");

	// Results come only from lines with a matched prefix
	a_emit_valid_line: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && emit) |-> (decided && match_q))
		else $error("result from undecided or failed line");

	// A stalled result holds its contents
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("output changed while stalled");
`endif

endmodule
